### hdl/assert_macros.svh
// Assertion shorthands for the RTL, used by ftcs_heat_diffusion_1d.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hdl/fhd_pkg.sv
package fhd_pkg;

   // request action codes
   localparam logic [1:0] ACT_LOAD = 2'd0;
   localparam logic [1:0] ACT_STEP = 2'd1;
   localparam logic [1:0] ACT_EMIT = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_ALPHA = 2'd0;
   localparam logic [1:0] CSR_LEFT  = 2'd1;
   localparam logic [1:0] CSR_RIGHT = 2'd2;
   localparam logic [1:0] CSR_GRID  = 2'd3;

   localparam int IDX_W = 6;

   localparam logic [15:0] ALPHA_MAX   = 16'd32768;
   localparam logic [15:0] ALPHA_RESET = 16'd16384;
   localparam logic [6:0]  GRID_MIN    = 7'd3;
   localparam logic [6:0]  GRID_RESET  = 7'd64;

   // control that travels with one grid point through the update pipeline
   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] index;
      logic             last;
      logic             use_ftcs;
   } pt_ctrl_type;

endpackage

### hdl/fhd_ram.sv
module fhd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old word on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/fhd_update.sv
module fhd_update import fhd_pkg::*; #(
   parameter int TEMP_WIDTH = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic [15:0]                  alpha_gain,
   input  pt_ctrl_type                  ctrl_in,
   input  logic signed [TEMP_WIDTH-1:0] left_temp,
   input  logic signed [TEMP_WIDTH-1:0] mid_temp,
   input  logic signed [TEMP_WIDTH-1:0] right_temp,
   input  logic signed [TEMP_WIDTH-1:0] bypass_temp,
   output pt_ctrl_type                  ctrl_out,
   output logic signed [TEMP_WIDTH-1:0] value_out,
   output logic                         busy
);

   localparam int LW = TEMP_WIDTH + 2;
   localparam int PW = TEMP_WIDTH + 19;
   localparam int SW = TEMP_WIDTH + 4;
   localparam logic signed [SW-1:0] SUM_MAX =
      {{(SW - TEMP_WIDTH + 1){1'b0}}, {(TEMP_WIDTH - 1){1'b1}}};
   localparam logic signed [SW-1:0] SUM_MIN = ~SUM_MAX;

   pt_ctrl_type                  ctrl_s1_ff, ctrl_s2_ff;
   logic signed [LW-1:0]         lap_s1_ff, lap_in;
   logic signed [TEMP_WIDTH-1:0] mid_s1_ff, byp_s1_ff, mid_s2_ff, byp_s2_ff;
   logic signed [PW-1:0]         prod_s2_ff, prod_in;
   logic [15:0]                  alpha_lim;
   logic signed [PW-1:0]         alpha_ext, lap_ext;
   logic signed [SW-1:0]         sum;
   logic signed [TEMP_WIDTH-1:0] sum_sat;

   // stage 1: discrete Laplacian
   assign lap_in = LW'(right_temp) - (LW'(mid_temp) <<< 1) + LW'(left_temp);

   // stage 2: scale by the clamped diffusion number
   assign alpha_lim = (alpha_gain > ALPHA_MAX) ? ALPHA_MAX : alpha_gain;
   assign alpha_ext = PW'($signed({1'b0, alpha_lim}));
   assign lap_ext   = PW'(lap_s1_ff);
   assign prod_in   = PW'(alpha_ext * lap_ext);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_s1_ff <= '0;
         ctrl_s2_ff <= '0;
      end else if (en) begin
         ctrl_s1_ff <= ctrl_in;
         ctrl_s2_ff <= ctrl_s1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lap_s1_ff  <= lap_in;
         mid_s1_ff  <= mid_temp;
         byp_s1_ff  <= bypass_temp;
         prod_s2_ff <= prod_in;
         mid_s2_ff  <= mid_s1_ff;
         byp_s2_ff  <= byp_s1_ff;
      end
   end

   // floor shift by 16, add, saturate
   always_comb begin
      sum = SW'(mid_s2_ff) + SW'($signed(prod_s2_ff[PW-1:16]));
      if (sum > SUM_MAX) begin
         sum_sat = SUM_MAX[TEMP_WIDTH-1:0];
      end else if (sum < SUM_MIN) begin
         sum_sat = SUM_MIN[TEMP_WIDTH-1:0];
      end else begin
         sum_sat = sum[TEMP_WIDTH-1:0];
      end
   end

   assign value_out = ctrl_s2_ff.use_ftcs ? sum_sat : byp_s2_ff;
   assign ctrl_out  = ctrl_s2_ff;
   assign busy      = ctrl_s1_ff.valid | ctrl_s2_ff.valid;

endmodule

### hdl/ftcs_heat_diffusion_1d.sv
// One-dimensional explicit heat diffusion engine, Q11.12 temperatures.
// Request channel (req_valid / req_stall): a load word writes one grid point;
// a step word advances the field one time step and then streams every point;
// an emit word streams the field without stepping. Both write left_temp /
// right_temp into the boundary points as they stream; a step reads the stored
// boundary values as neighbors.
// Response channel (rsp_valid / rsp_stall): one word per grid point, index 0
// first, rsp_last_point set on the last point in use (clamped grid size - 1).
// A step or emit word holds req_stall high while the sweep reads point 0,
// issues every point from the field RAM's single read port, one point per
// cycle unless the response stalls, and drains the two-stage update pipeline;
// only then is the next word taken.
// A stalled response holds the whole sweep: counter, read address and
// pipeline freeze together, so no point is lost.
// Reset (synchronous) restores the register defaults and clears the per-entry
// valid bits, so the field reads as all zeros without a clearing pass.
// Configuration writes are one-cycle strobes; the user must issue them only
// between words, as the block itself does not enforce this.

`include "assert_macros.svh"

module ftcs_heat_diffusion_1d import fhd_pkg::*; #(
   parameter int MAX_POINTS = 64,
   parameter int TEMP_WIDTH = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_action,
   input  logic [IDX_W-1:0]        req_point_index,
   input  logic signed [23:0]      req_point_value,
   // response channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [IDX_W-1:0]        rsp_out_index,
   output logic signed [23:0]      rsp_out_temp,
   output logic                    rsp_last_point,
   // configuration port
   input  logic                    csr_wen,
   input  logic [1:0]              csr_index,
   input  logic [23:0]             csr_wdata
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int WB = (TEMP_WIDTH > 24) ? TEMP_WIDTH : 24;
   localparam logic [6:0] GRID_MAX = 7'(MAX_POINTS);
   localparam logic signed [WB-1:0] STORE_MAX =
      {{(WB - TEMP_WIDTH + 1){1'b0}}, {(TEMP_WIDTH - 1){1'b1}}};
   localparam logic signed [WB-1:0] STORE_MIN = ~STORE_MAX;
   localparam logic signed [WB-1:0] WORD_MAX = {{(WB - 23){1'b0}}, {23{1'b1}}};
   localparam logic signed [WB-1:0] WORD_MIN = ~WORD_MAX;

   typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_DRAIN} state_type;

   // 24-bit value into the store width, saturating
   function automatic logic signed [TEMP_WIDTH-1:0] to_store(input logic signed [23:0] v);
      logic signed [WB-1:0] e;
      e = WB'(v);
      if (e > STORE_MAX) begin
         e = STORE_MAX;
      end else if (e < STORE_MIN) begin
         e = STORE_MIN;
      end
      return e[TEMP_WIDTH-1:0];
   endfunction

   // stored value out to the 24-bit response word, saturating
   function automatic logic signed [23:0] to_word(input logic signed [TEMP_WIDTH-1:0] v);
      logic signed [WB-1:0] e;
      e = WB'(v);
      if (e > WORD_MAX) begin
         e = WORD_MAX;
      end else if (e < WORD_MIN) begin
         e = WORD_MIN;
      end
      return e[23:0];
   endfunction

   state_type                    state_ff, state_in;
   logic [CW-1:0]                cnt_ff, cnt_in;
   logic                         step_ff, step_in;
   logic signed [TEMP_WIDTH-1:0] prev_old_ff, prev_old_in;
   logic signed [TEMP_WIDTH-1:0] mid_ff, mid_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]             rsp_index_ff, rsp_index_in;
   logic signed [23:0]           rsp_temp_ff, rsp_temp_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic [15:0]                  alpha_ff;
   logic [23:0]                  left_ff, right_ff;
   logic [6:0]                   grid_ff;

   logic [MAX_POINTS-1:0]        valid_ff, valid_in;
   logic                         rd_valid_ff;

   logic [CW-1:0]                n_pts;
   logic                         advance, accept;
   logic [AW-1:0]                rd_addr, wr_addr;
   logic [TEMP_WIDTH-1:0]        ram_q, wr_data;
   logic                         wr_en, load_we, pipe_we;
   logic signed [TEMP_WIDTH-1:0] rd_word, left_store, right_store, bypass;
   logic                         first_pt, last_pt;
   pt_ctrl_type                  pa_ctrl, pb_ctrl;
   logic signed [TEMP_WIDTH-1:0] pb_value;
   logic                         pipe_busy;

   // points in use, clamped to the legal range
   always_comb begin
      if (grid_ff < GRID_MIN) begin
         n_pts = CW'(GRID_MIN);
      end else if (grid_ff > GRID_MAX) begin
         n_pts = CW'(GRID_MAX);
      end else begin
         n_pts = CW'(grid_ff);
      end
   end

   // the whole sweep moves only when the response register can take a word
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   assign left_store  = to_store($signed(left_ff));
   assign right_store = to_store($signed(right_ff));

   // never-written entries read as zero
   assign rd_word = rd_valid_ff ? $signed(ram_q) : '0;

   // stage A: cnt_ff = j + 1 while point j is issued; window holds j-1 and j
   assign first_pt = (cnt_ff == CW'(1));
   assign last_pt  = (cnt_ff == n_pts);
   always_comb begin
      pa_ctrl.valid    = (state_ff == ST_SWEEP) && (cnt_ff != '0);
      pa_ctrl.index    = IDX_W'(cnt_ff - CW'(1));
      pa_ctrl.last     = last_pt;
      pa_ctrl.use_ftcs = step_ff && !first_pt && !last_pt;
      if (first_pt) begin
         bypass = left_store;
      end else if (last_pt) begin
         bypass = right_store;
      end else begin
         bypass = mid_ff;
      end
   end

   fhd_update #(
      .TEMP_WIDTH (TEMP_WIDTH)
   ) u_update (
      .clock       (clock),
      .reset       (reset),
      .en          (advance),
      .alpha_gain  (alpha_ff),
      .ctrl_in     (pa_ctrl),
      .left_temp   (prev_old_ff),
      .mid_temp    (mid_ff),
      .right_temp  (rd_word),
      .bypass_temp (bypass),
      .ctrl_out    (pb_ctrl),
      .value_out   (pb_value),
      .busy        (pipe_busy)
   );

   // write port: loads while idle, sweep write-back otherwise
   assign load_we = accept && (req_action == ACT_LOAD) &&
                    ({1'b0, req_point_index} < GRID_MAX);
   assign pipe_we = advance && pb_ctrl.valid;
   assign wr_en   = load_we || pipe_we;
   assign wr_addr = pipe_we ? pb_ctrl.index[AW-1:0] : req_point_index[AW-1:0];
   assign wr_data = pipe_we ? pb_value : to_store(req_point_value);

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   // read the entry the counter will point at next; a held counter re-reads
   assign rd_addr = (cnt_in < CW'(MAX_POINTS)) ? cnt_in[AW-1:0] : '0;

   fhd_ram #(
      .WIDTH (TEMP_WIDTH),
      .DEPTH (MAX_POINTS)
   ) u_field_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      step_in      = step_ff;
      prev_old_in  = prev_old_ff;
      mid_in       = mid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_temp_in  = rsp_temp_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               unique case (req_action)
                  ACT_STEP: begin
                     step_in  = 1'b1;
                     state_in = ST_SWEEP;
                  end
                  ACT_EMIT: begin
                     step_in  = 1'b0;
                     state_in = ST_SWEEP;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            if (advance) begin
               // shift the old-value window one point right
               prev_old_in = mid_ff;
               mid_in      = rd_word;
               if (cnt_ff == n_pts) begin
                  cnt_in   = '0;
                  state_in = ST_DRAIN;
               end else begin
                  cnt_in = cnt_ff + CW'(1);
               end
            end
         end
         ST_DRAIN: begin
            cnt_in = '0;
            if (!pipe_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (advance) begin
         rsp_valid_in = pb_ctrl.valid;
         rsp_index_in = pb_ctrl.index;
         rsp_temp_in  = to_word(pb_value);
         rsp_last_in  = pb_ctrl.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         step_ff      <= 1'b0;
         prev_old_ff  <= '0;
         mid_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         step_ff      <= step_in;
         prev_old_ff  <= prev_old_in;
         mid_ff       <= mid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_index_ff <= rsp_index_in;
      rsp_temp_ff  <= rsp_temp_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // entry valid bits and the registered valid of the read entry
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RESET;
         left_ff  <= '0;
         right_ff <= '0;
         grid_ff  <= GRID_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_ALPHA: alpha_ff <= csr_wdata[15:0];
            CSR_LEFT:  left_ff  <= csr_wdata;
            CSR_RIGHT: right_ff <= csr_wdata;
            CSR_GRID:  grid_ff  <= csr_wdata[6:0];
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_index  = rsp_index_ff;
   assign rsp_out_temp   = rsp_temp_ff;
   assign rsp_last_point = rsp_last_ff;

   // the last-point flag sits on the final grid index
   `ASSERT_IMPLIES(a_last_index, clock, reset, rsp_valid_ff && rsp_last_ff,
      rsp_out_index == IDX_W'(n_pts - CW'(1)))
   // write-back never lands on the entry being read mid-sweep
   `ASSERT_IMPLIES(a_no_rw_clash, clock, reset,
      (state_ff == ST_SWEEP) && (cnt_ff != n_pts) && pipe_we, wr_addr != rd_addr)
   // requests are taken only with the update pipeline empty
   `ASSERT_IMPLIES(a_idle_empty, clock, reset, state_ff == ST_IDLE, !pipe_busy)

endmodule

### test/ftcs_heat_diffusion_1d_tb.sv
`timescale 1ns / 100ps

module ftcs_heat_diffusion_1d_tb;
   import fhd_pkg::*;

   localparam int          GRID_POINTS   = 64;   // store depth of the block
   localparam int          SETTLE_CYCLES = 80;   // one full sweep plus pipeline drain
   localparam int          HOLD_CYCLES   = 400;  // long receiver hold-off
   localparam int          ITEM_TARGET   = 280;
   localparam logic [1:0]  ACT_UNUSED    = 2'd3;
   localparam logic [23:0] TEMP_MAX      = 24'h7FFFFF;
   localparam logic [23:0] TEMP_MIN      = 24'h800000;

   // one reported grid point
   typedef struct {
      logic [5:0]         index;
      logic signed [23:0] temp;
      logic               last;
   } grid_point_type;

   // Keep a shadow copy of the field and the registers, predict every emitted
   // point and compare the block's words against it in order.
   class heat_field_scoreboard;
      logic signed [23:0] temps[GRID_POINTS];
      logic [15:0]        alpha_gain;
      logic signed [23:0] left_temp;
      logic signed [23:0] right_temp;
      logic [6:0]         grid_size;
      grid_point_type     expected_points[$];
      int                 errors;
      int                 loads, steps, emits, ignored, compared;

      function new();
         foreach (temps[i]) temps[i] = '0;
         alpha_gain = ALPHA_RESET;
         left_temp  = '0;
         right_temp = '0;
         grid_size  = GRID_RESET;
         errors = 0;
         loads = 0; steps = 0; emits = 0; ignored = 0; compared = 0;
      endfunction

      function int points_in_use();
         if (grid_size < GRID_MIN) return GRID_MIN;
         if (grid_size > GRID_POINTS) return GRID_POINTS;
         return grid_size;
      endfunction

      function int pending();
         return expected_points.size();
      endfunction

      function void write_reg(logic [1:0] idx, logic [23:0] data);
         case (idx)
            CSR_ALPHA: alpha_gain = data[15:0];
            CSR_LEFT:  left_temp  = data;
            CSR_RIGHT: right_temp = data;
            CSR_GRID:  grid_size  = data[6:0];
         endcase
      endfunction

      // explicit update of one interior point from the old neighbor values
      function logic signed [23:0] diffuse(longint left_v, longint mid_v, longint right_v);
         longint lap, gain, delta, sum;
         lap   = right_v - 2 * mid_v + left_v;
         gain  = (alpha_gain > ALPHA_MAX) ? ALPHA_MAX : alpha_gain;
         delta = (gain * lap) >>> 16;   // floor division by 2^16
         sum   = mid_v + delta;
         if (sum > longint'(8388607)) sum = 8388607;
         if (sum < longint'(-8388608)) sum = -8388608;
         return sum[23:0];
      endfunction

      function void emit_field(int n);
         grid_point_type pt;
         temps[0]     = left_temp;
         temps[n - 1] = right_temp;
         for (int i = 0; i < n; i++) begin
            pt.index = i[5:0];
            pt.temp  = temps[i];
            pt.last  = (i == n - 1);
            expected_points.push_back(pt);
         end
      endfunction

      function void note_word(logic [1:0] act, logic [5:0] idx, logic [23:0] val);
         int n;
         logic signed [23:0] left_old, cur;
         n = points_in_use();
         case (act)
            ACT_LOAD: begin
               temps[idx] = val;
               loads++;
            end
            ACT_STEP: begin
               // sweep left to right, carrying the old value of the left neighbor
               left_old = temps[0];
               for (int i = 1; i + 1 < n; i++) begin
                  cur      = temps[i];
                  temps[i] = diffuse(left_old, cur, temps[i + 1]);
                  left_old = cur;
               end
               emit_field(n);
               steps++;
            end
            ACT_EMIT: begin
               emit_field(n);
               emits++;
            end
            default: ignored++;
         endcase
      endfunction

      function void check_point(logic [5:0] idx, logic signed [23:0] temp, logic last);
         grid_point_type exp_pt;
         if (expected_points.size() == 0) begin
            $error("unexpected word: out_index %0d out_temp %0d last_point %0b",
                   idx, temp, last);
            errors++;
            return;
         end
         exp_pt = expected_points.pop_front();
         compared++;
         if (idx !== exp_pt.index) begin
            $error("out_index: expected %0d, actual %0d", exp_pt.index, idx);
            errors++;
         end
         if (temp !== exp_pt.temp) begin
            $error("out_temp at point %0d: expected %0d, actual %0d",
                   exp_pt.index, exp_pt.temp, temp);
            errors++;
         end
         if (last !== exp_pt.last) begin
            $error("last_point at point %0d: expected %0b, actual %0b",
                   exp_pt.index, exp_pt.last, last);
            errors++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [1:0]        req_action;
   logic [IDX_W-1:0]  req_point_index;
   logic signed [23:0] req_point_value;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [IDX_W-1:0]  rsp_out_index;
   logic signed [23:0] rsp_out_temp;
   logic              rsp_last_point;
   logic              csr_wen;
   logic [1:0]        csr_index;
   logic [23:0]       csr_wdata;

   heat_field_scoreboard field_sb;
   int                   burst_left;
   int                   settings_used;
   logic                 hold_off_request;

   ftcs_heat_diffusion_1d i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_point_index (req_point_index),
      .req_point_value (req_point_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_index   (rsp_out_index),
      .rsp_out_temp    (rsp_out_temp),
      .rsp_last_point  (rsp_last_point),
      .csr_wen         (csr_wen),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // 12 ns clock
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Offer one request word and hold it until the block takes it. The sender
   // works in bursts; at the start of each burst it idles for a random gap.
   // Called at a falling edge, returns at the falling edge after acceptance
   // with valid still high, so back-to-back words never drop valid.
   task automatic send_word(input logic [1:0] act, input logic [5:0] idx,
                            input logic [23:0] val);
      if (burst_left == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         // mostly short bursts, now and then a long stretch with no gaps
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 10);
      end
      req_valid       = 1'b1;
      req_action      = act;
      req_point_index = idx;
      req_point_value = val;
      do @(posedge clock); while (req_stall);
      field_sb.note_word(act, idx, val);
      burst_left--;
      @(negedge clock);
   endtask

   // Program all four registers once the block has gone idle. Upper bits of
   // the write data beyond each register's width carry random junk.
   task automatic configure(input logic [15:0] alpha, input logic [23:0] left_b,
                            input logic [23:0] right_b, input logic [6:0] grid);
      logic [23:0] data [4];
      logic [31:0] junk;
      req_valid = 1'b0;
      while (field_sb.pending() != 0) @(negedge clock);
      // a trailing load gives no response, so let any sweep finish first
      repeat (SETTLE_CYCLES) @(negedge clock);
      junk = $urandom;
      data[CSR_ALPHA] = {junk[7:0], alpha};
      data[CSR_LEFT]  = left_b;
      data[CSR_RIGHT] = right_b;
      data[CSR_GRID]  = {junk[24:8], grid};
      for (int k = CSR_ALPHA; k <= CSR_GRID; k++) begin
         csr_wen   = 1'b1;
         csr_index = k[1:0];
         csr_wdata = data[k];
         @(posedge clock);
         field_sb.write_reg(k[1:0], data[k]);
         @(negedge clock);
      end
      csr_wen = 1'b0;
      settings_used++;
   endtask

   // Receiver: compare every accepted response word at the rising edge, then
   // pick the stall for the next cycle at the falling edge. The stall rate
   // changes at random, no stalls being the likeliest pick; a long hold-off fills the block on request.
   initial begin
      int cycle_count;
      int stall_pct;
      int hold_left;
      rsp_stall        = 1'b0;
      hold_off_request = 1'b0;
      cycle_count      = 0;
      stall_pct        = 0;
      hold_left        = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            field_sb.check_point(rsp_out_index, rsp_out_temp, rsp_last_point);
         @(negedge clock);
         cycle_count++;
         if (cycle_count % 256 == 0) begin
            case ($urandom_range(0, 4))
               0, 1: stall_pct = 0;
               2:    stall_pct = 20;
               3:    stall_pct = 50;
               default: stall_pct = 75;
            endcase
         end
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left        = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall = 1'b1;
         end else begin
            rsp_stall = ($urandom_range(1, 100) <= stall_pct);
         end
      end
   end

   // Hard limit on the run
   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      int phase_items;
      int n;
      int r;
      logic [5:0]  idx;
      logic [23:0] val;
      logic [15:0] alpha;
      logic [23:0] left_b, right_b;
      logic [6:0]  grid;

      field_sb        = new();
      burst_left      = 0;
      settings_used   = 0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_action      = ACT_LOAD;
      req_point_index = '0;
      req_point_value = '0;
      csr_wen         = 1'b0;
      csr_index       = CSR_ALPHA;
      csr_wdata       = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: reset settings, empty field, extreme values on the
      // boundaries (stale until forced) and beside them, an unused code.
      send_word(ACT_EMIT, 6'd0, 24'd0);
      send_word(ACT_LOAD, 6'd0, TEMP_MAX);
      send_word(ACT_LOAD, 6'd1, TEMP_MIN);
      send_word(ACT_LOAD, 6'd2, TEMP_MAX);
      send_word(ACT_LOAD, 6'd63, TEMP_MIN);
      send_word(ACT_LOAD, 6'd62, TEMP_MAX);
      send_word(ACT_STEP, 6'd0, 24'd0);
      send_word(ACT_UNUSED, 6'd63, TEMP_MAX);
      send_word(ACT_EMIT, 6'd0, 24'd0);

      // Oversized alpha, grid size below range, extreme boundaries, and a
      // load beyond the grid that must survive untouched.
      configure(16'hFFFF, TEMP_MAX, TEMP_MIN, 7'd0);
      send_word(ACT_LOAD, 6'd1, TEMP_MIN);
      send_word(ACT_LOAD, 6'd0, TEMP_MAX);
      send_word(ACT_LOAD, 6'd40, 24'h123456);
      send_word(ACT_STEP, 6'd0, 24'd0);
      send_word(ACT_EMIT, 6'd0, 24'd0);

      // Zero alpha, grid size above range: the point loaded earlier shows up
      configure(16'd0, TEMP_MIN, TEMP_MAX, 7'd127);
      send_word(ACT_STEP, 6'd0, 24'd0);
      send_word(ACT_LOAD, 6'd5, 24'd1);
      send_word(ACT_STEP, 6'd0, 24'd0);

      // Largest legal alpha on the smallest grid
      configure(ALPHA_MAX, 24'h000FFF, 24'hFFF000, GRID_MIN);
      send_word(ACT_LOAD, 6'd2, TEMP_MAX);
      send_word(ACT_STEP, 6'd0, 24'd0);
      send_word(ACT_EMIT, 6'd0, 24'd0);

      // Random phases: new settings, then a batch of mostly load-and-step
      // traffic with random content, plus plain emits and unused codes.
      while (field_sb.loads + field_sb.steps + field_sb.emits < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0:       alpha = 16'd0;
            1:       alpha = ALPHA_MAX;
            2:       alpha = 16'($urandom_range(32769, 65535));
            default: alpha = 16'($urandom_range(0, 32768));
         endcase
         case ($urandom_range(0, 9))
            0:       left_b = TEMP_MAX;
            1:       left_b = TEMP_MIN;
            default: left_b = 24'($urandom);
         endcase
         case ($urandom_range(0, 9))
            0:       right_b = TEMP_MIN;
            1:       right_b = TEMP_MAX;
            default: right_b = 24'($urandom);
         endcase
         case ($urandom_range(0, 9))
            0:       grid = 7'($urandom_range(0, 2));
            1:       grid = 7'($urandom_range(65, 127));
            2:       grid = 7'($urandom_range(33, 64));
            default: grid = 7'($urandom_range(3, 16));
         endcase
         configure(alpha, left_b, right_b, grid);
         n = field_sb.points_in_use();

         // second random phase: receiver holds off while words keep coming
         if (settings_used == 5) hold_off_request = 1'b1;

         phase_items = $urandom_range(15, 35);
         repeat (phase_items) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
               idx = (r < 45) ? 6'($urandom_range(0, n - 1)) : 6'($urandom_range(0, 63));
               case ($urandom_range(0, 7))
                  0:       val = TEMP_MAX;
                  1:       val = TEMP_MIN;
                  default: val = 24'($urandom);
               endcase
               send_word(ACT_LOAD, idx, val);
            end else if (r < 80) begin
               send_word(ACT_STEP, 6'($urandom_range(0, 63)), 24'($urandom));
            end else if (r < 92) begin
               send_word(ACT_EMIT, 6'($urandom_range(0, 63)), 24'($urandom));
            end else begin
               send_word(ACT_UNUSED, 6'($urandom_range(0, 63)), 24'($urandom));
            end
         end
      end

      // Drain: drop valid, wait for every expected point, then let the block
      // settle and catch any stray word.
      req_valid = 1'b0;
      while (field_sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("covered %0d loads, %0d steps, %0d emits, %0d unused codes over %0d settings",
               field_sb.loads, field_sb.steps, field_sb.emits, field_sb.ignored,
               settings_used);
      $display("%0d grid points compared, %0d mismatches", field_sb.compared,
               field_sb.errors);
      if (field_sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
